[hw/rtl/crb_pkg.sv]
// shared types and constants for the chunk reorder buffer
package crb_pkg;

  // default number of slots in the slot store
  localparam int SLOTS_DEF = 16;

  // reset value of the reorder depth register
  localparam logic [3:0] MAX_AHEAD_RST = 4'd15;

  // field widths
  localparam int IDX_W  = 32;
  localparam int PAY_W  = 32;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 3;
  localparam int CFG_W  = 4;

  // operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_DELIVERED = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_FAR   = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_NOT_READY = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 3'd4;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

[hw/rtl/crb_ram.sv]
// generic single write port ram with registered read
module crb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/chunk_reorder_buffer.sv]
// top level of the chunk reorder buffer: slot store, sequencer and result register
//
//   channel   direction  handshake               contents
//   in        request    in_valid / in_stall     operation, chunk_number, payload,
//                                                length, buffer_room
//   out       result     out_valid / out_stall   status, delivered_payload,
//                                                delivered_length, delivered_index
//   cfg       write      cfg_wr_en               cfg_wr_data (reorder depth)
//
// each request is accepted in ST_IDLE, where the accept issues the slot store read;
// ST_EXEC then applies the read data, writes an inserted chunk into the store and
// loads the result. the slot store read is registered, so its data is applied in
// ST_EXEC; one request is in flight at a time.
// a new request is taken while the previous result is being taken at the same edge.
// rst is synchronous; it clears the full bits, the head and the index at once,
// no clearing pass. a depth write clears them the same way.
// out_stall holds the result register and, through in_stall, the input side.
module chunk_reorder_buffer #(
  parameter int SLOTS = crb_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        cfg_wr_en,
  input  logic [crb_pkg::CFG_W-1:0]   cfg_wr_data,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        operation,
  input  logic [crb_pkg::IDX_W-1:0]   chunk_number,
  input  logic [crb_pkg::PAY_W-1:0]   payload,
  input  logic [crb_pkg::LEN_W-1:0]   length,
  input  logic [crb_pkg::LEN_W-1:0]   buffer_room,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [crb_pkg::STAT_W-1:0]  status,
  output logic [crb_pkg::PAY_W-1:0]   delivered_payload,
  output logic [crb_pkg::LEN_W-1:0]   delivered_length,
  output logic [crb_pkg::IDX_W-1:0]   delivered_index
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CAP_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CAP_W > crb_pkg::CFG_W + 1) ? CAP_W : crb_pkg::CFG_W + 1;
  localparam int ENT_W  = crb_pkg::LEN_W + crb_pkg::PAY_W;
  localparam int CAP_RST_I = (int'(crb_pkg::MAX_AHEAD_RST) + 1 > SLOTS) ?
                             SLOTS : int'(crb_pkg::MAX_AHEAD_RST) + 1;
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(CAP_RST_I);

  // control state
  crb_pkg::state_t            state, state_next;
  logic [CAP_W-1:0]           cap;
  logic [crb_pkg::IDX_W-1:0]  next_index;
  logic [SLOT_W-1:0]          head_slot;
  logic [SLOTS-1:0]           slot_full;

  // request held for ST_EXEC
  logic                       op_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [crb_pkg::STAT_W-1:0] ins_status_q;
  logic                       sel_full_q;
  logic [crb_pkg::PAY_W-1:0]  payload_q;
  logic [crb_pkg::LEN_W-1:0]  length_q;
  logic [crb_pkg::LEN_W-1:0]  room_q;

  // sequencer outputs
  logic in_accept;
  logic exec;

  // combinational request decode
  logic [CMP_W-1:0]           cap_req;
  logic [CAP_W-1:0]           cap_next;
  logic [crb_pkg::IDX_W-1:0]  ahead;
  logic [CAP_W:0]             slot_sum;
  logic [CAP_W:0]             slot_wrap;
  logic [SLOT_W-1:0]          ins_slot;
  logic [crb_pkg::STAT_W-1:0] ins_status;
  logic [SLOT_W-1:0]          sel_slot;

  // ST_EXEC results
  logic [ENT_W-1:0]           ram_rdata;
  logic [crb_pkg::PAY_W-1:0]  head_payload;
  logic [crb_pkg::LEN_W-1:0]  head_length;
  logic                       ins_write;
  logic                       deq_ok;
  logic [crb_pkg::STAT_W-1:0] deq_status;
  logic [CAP_W-1:0]           head_inc;
  logic [SLOT_W-1:0]          head_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      crb_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = crb_pkg::ST_EXEC;
        end
      end
      crb_pkg::ST_EXEC: begin
        state_next = crb_pkg::ST_IDLE;
      end
      default: begin
        state_next = crb_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    exec     = 1'b0;
    case (state)
      crb_pkg::ST_IDLE: begin
        in_stall = out_valid && out_stall;
      end
      crb_pkg::ST_EXEC: begin
        exec = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // slot count from the depth register, limited to the store size
  always_comb begin
    cap_req  = CMP_W'(cfg_wr_data) + CMP_W'(1);
    cap_next = (cap_req > CMP_W'(SLOTS)) ? CAP_W'(SLOTS) : CAP_W'(cap_req);
  end

  // insert: range check and slot position, one wrap at the slot count
  always_comb begin
    ahead     = chunk_number - next_index;
    slot_sum  = (CAP_W + 1)'(head_slot) + (CAP_W + 1)'(ahead[CAP_W-1:0]);
    slot_wrap = (slot_sum >= (CAP_W + 1)'(cap)) ? slot_sum - (CAP_W + 1)'(cap) : slot_sum;
    ins_slot  = slot_wrap[SLOT_W-1:0];
    if (chunk_number < next_index) begin
      ins_status = crb_pkg::STATUS_DELIVERED;
    end else if (ahead >= crb_pkg::IDX_W'(cap)) begin
      ins_status = crb_pkg::STATUS_TOO_FAR;
    end else begin
      ins_status = crb_pkg::STATUS_OK;
    end
    sel_slot = (operation == crb_pkg::OP_INSERT) ? ins_slot : head_slot;
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q         <= operation;
      slot_q       <= ins_slot;
      ins_status_q <= ins_status;
      sel_full_q   <= slot_full[sel_slot];
      payload_q    <= payload;
      length_q     <= length;
      room_q       <= buffer_room;
    end
  end

  // slot contents: length over descriptor
  crb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ins_write),
    .waddr (slot_q),
    .wdata ({length_q, payload_q}),
    .re    (in_accept),
    .raddr (head_slot),
    .rdata (ram_rdata)
  );

  // ST_EXEC: apply read data
  always_comb begin
    head_payload = ram_rdata[crb_pkg::PAY_W-1:0];
    head_length  = ram_rdata[ENT_W-1:crb_pkg::PAY_W];
    ins_write    = exec && (op_q == crb_pkg::OP_INSERT) &&
                   (ins_status_q == crb_pkg::STATUS_OK) && !sel_full_q;
    if (!sel_full_q) begin
      deq_status = crb_pkg::STATUS_NOT_READY;
    end else if (head_length > room_q) begin
      deq_status = crb_pkg::STATUS_TOO_LARGE;
    end else begin
      deq_status = crb_pkg::STATUS_OK;
    end
    deq_ok    = exec && (op_q == crb_pkg::OP_DEQUEUE) &&
                (deq_status == crb_pkg::STATUS_OK);
    head_inc  = CAP_W'(head_slot) + CAP_W'(1);
    head_next = (head_inc >= cap) ? '0 : head_inc[SLOT_W-1:0];
  end

  // buffer state: depth write clears, insert sets, dequeue frees and advances
  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_RST;
      next_index <= '0;
      head_slot  <= '0;
      slot_full  <= '0;
    end else if (cfg_wr_en) begin
      cap        <= cap_next;
      next_index <= '0;
      head_slot  <= '0;
      slot_full  <= '0;
    end else begin
      if (ins_write) begin
        slot_full[slot_q] <= 1'b1;
      end
      if (deq_ok) begin
        slot_full[head_slot] <= 1'b0;
        next_index           <= next_index + 1'b1;
        head_slot            <= head_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (op_q == crb_pkg::OP_INSERT) begin
        status            <= ins_status_q;
        delivered_payload <= '0;
        delivered_length  <= '0;
        delivered_index   <= '0;
      end else begin
        status            <= deq_status;
        delivered_payload <= deq_ok ? head_payload : '0;
        delivered_length  <= deq_ok ? head_length : '0;
        delivered_index   <= deq_ok ? next_index : '0;
      end
    end
  end

  // checks
  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(head_slot) < 32'(cap))
    else $error("head slot beyond slot count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != crb_pkg::STATUS_OK) |->
      (delivered_payload == '0) && (delivered_length == '0) && (delivered_index == '0))
    else $error("refused request carries delivery data");

  a_deq_advance: assert property (@(posedge clk) disable iff (rst)
    deq_ok && !cfg_wr_en |=> next_index == $past(next_index) + 1'b1)
    else $error("index did not advance on delivery");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == crb_pkg::ST_EXEC))
    else $error("result without a request in progress");

endmodule
